### sv/perlin3d_pkg.sv
// Shared types, constants and sequencer states for the 3D Perlin noise block.
`default_nettype none
package perlin3d_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int TABLE_ENTRIES = 512;
  localparam int TABLE_AW      = $clog2(TABLE_ENTRIES);

  localparam logic [63:0] RNG_MUL  = 64'h2545F4914F6CDD1D;
  localparam logic [13:0] SEED_MUL = 14'd12907;
  localparam int XS_A = 12;
  localparam int XS_B = 25;
  localparam int XS_C = 27;

  localparam logic [16:0] NOISE_MAX = 17'h10000;

  localparam logic REQ_RESEED = 1'b0;
  localparam logic REQ_EVAL   = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
  } noise_req_t;

  typedef struct packed {
    logic [16:0] noise_value;
    logic        is_reseed_ack;
  } noise_res_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_MUL_LO,
    SQ_MUL_HI,
    SQ_FILL,
    SQ_SWAP_RD,
    SQ_SWAP_WI,
    SQ_SWAP_WR,
    SQ_DONE
  } seq_state_t;

endpackage
`default_nettype wire

### sv/perlin3d_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
`default_nettype none
module perlin3d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
`default_nettype wire

### sv/perlin3d_lerp.sv
// Two-stage fixed-point lerp a + floor((b - a) * t / 2^FB) with a split multiply.
`default_nettype none
module perlin3d_lerp #(
  parameter int AW = 19,
  parameter int TW = 23,
  parameter int RW = 27,
  parameter int FB = 16
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [AW-1:0] a,
  input  wire logic signed [AW-1:0] b,
  input  wire logic signed [TW-1:0] t,
  output logic      signed [RW-1:0] y
);

  localparam int DW = AW + 1;
  localparam int LO = DW / 2;
  localparam int HI = DW - LO;
  localparam int PW = DW + TW;

  logic signed [DW-1:0]    diff;
  logic signed [LO:0]      lo_s;
  logic signed [HI-1:0]    hi_s;
  logic signed [LO+TW:0]   pl;
  logic signed [HI+TW-1:0] ph;
  logic signed [AW-1:0]    a_q;
  logic signed [PW-1:0]    prod;
  logic signed [PW-1:0]    shq;
  logic signed [RW-1:0]    y_next;

  assign diff = DW'(b) - DW'(a);
  assign lo_s = $signed({1'b0, diff[LO-1:0]});
  assign hi_s = $signed(diff[DW-1:LO]);

  // Recombine the partial products, floor-shift and add the base.
  assign prod   = (PW'(ph) <<< LO) + PW'(pl);
  assign shq    = prod >>> FB;
  assign y_next = RW'(shq + PW'(a_q));

  always_ff @(posedge clk) begin
    if (en) begin
      pl  <= lo_s * t;
      ph  <= hi_s * t;
      a_q <= a;
      y   <= y_next;
    end
  end

endmodule
`default_nettype wire

### sv/perlin_noise_3d.sv
// Top level of the improved 3D Perlin noise block with a reseedable table.
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  request  | in_valid / in_stall | in_data  (req_type, coord_x/y/z)
//  result   | out_valid/out_stall | out_data (noise_value, is_reseed_ack)
//  config   | cfg_we              | cfg_wdata (seed)
//
// Evaluate requests stream at one per cycle unless out_stall or a reseed
// holds the input; the path to the output register runs through the three
// dependent table lookups and the three levels of two-stage lerp multiplies.
// A reseed request waits until the pipeline is empty, then the sequencer
// fills the table and runs 512 swaps over the single write port of the
// table copies before it drops the ack into the output register.
// Reset (rst, synchronous) clears valids, the sequencer and the seed; the
// table holds nothing until the first reseed. out_stall, while out_valid is
// high, freezes the whole pipeline, including the registered table reads.
`default_nettype none
module perlin_noise_3d
  import perlin3d_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [63:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire noise_req_t  in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output noise_res_t       out_data
);

  localparam int F     = FRAC_BITS;
  localparam int FW    = F + 2;    // fraction and corner offsets, (-2, 2)
  localparam int MW    = F + 6;    // 6f - 15
  localparam int IW    = F + 7;    // inner fade term
  localparam int UW    = F + 7;    // fade weights, about (-31, 1]
  localparam int GW    = F + 3;    // gradients, (-4, 4)
  localparam int L1W   = F + 11;
  localparam int L2W   = F + 18;
  localparam int L3W   = F + 26;
  localparam int VW    = L3W + 1;
  localparam int QW    = VW + 16;
  localparam int RSH   = (F >= 16) ? F - 16 : 0;
  localparam int LSH   = (F < 16) ? 16 - F : 0;
  localparam int TAW   = TABLE_AW;
  localparam int NCOPY = 7;
  localparam int NSTG  = 11;

  localparam longint ONE_L = longint'(1) << F;
  localparam logic signed [FW-1:0] ONE_F = FW'(ONE_L);
  localparam logic signed [MW-1:0] C15   = MW'(15 * ONE_L);
  localparam logic signed [IW-1:0] C10   = IW'(10 * ONE_L);
  localparam logic signed [VW-1:0] ONE_V = VW'(ONE_L);
  localparam logic [QW-1:0]        QMAX  = QW'(NOISE_MAX);
  localparam logic [TAW-1:0]       LAST  = TAW'(TABLE_ENTRIES - 1);

  function automatic logic [63:0] xorshift(input logic [63:0] s);
    logic [63:0] t;
    t = s ^ (s >> XS_A);
    t = t ^ (t << XS_B);
    t = t ^ (t >> XS_C);
    return t;
  endfunction

  function automatic logic signed [GW-1:0] grad(input logic [3:0] h,
                                                input logic signed [FW-1:0] x,
                                                input logic signed [FW-1:0] y,
                                                input logic signed [FW-1:0] z);
    logic signed [GW-1:0] gu;
    logic signed [GW-1:0] gv;
    gu = (h < 4'd8) ? GW'(x) : GW'(y);
    if (h < 4'd4) begin
      gv = GW'(y);
    end else if (h == 4'd12 || h == 4'd14) begin
      gv = GW'(x);
    end else begin
      gv = GW'(z);
    end
    return (h[0] ? -gu : gu) + (h[1] ? -gv : gv);
  endfunction

  // ---------------------------------------------------------------------
  // Handshake and pipeline advance
  // ---------------------------------------------------------------------
  logic            adv;
  logic [NSTG-1:0] vld;
  logic            busy;
  logic            eval_acc;
  logic            reseed_acc;
  logic            ack;
  logic [63:0]     seed;

  seq_state_t seq_state;
  seq_state_t seq_state_next;

  // Advance the whole pipeline whenever the output register can move.
  assign adv  = !out_valid || !out_stall;
  assign busy = (seq_state != SQ_IDLE);

  // Hold requests while stalled or reseeding; hold a reseed until the pipe drains.
  assign in_stall   = !adv || busy || ((in_data.req_type == REQ_RESEED) && (|vld));
  assign eval_acc   = in_valid && !in_stall && (in_data.req_type == REQ_EVAL);
  assign reseed_acc = in_valid && !in_stall && (in_data.req_type == REQ_RESEED);

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (cfg_we) begin
      seed <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], eval_acc};
    end
  end

  // ---------------------------------------------------------------------
  // Stage 0: split coordinates into lattice index and signed fraction
  // ---------------------------------------------------------------------
  logic signed [31:0]   crd      [3];
  logic [7:0]           idx_in   [3];
  logic signed [FW-1:0] frac_in  [3];
  logic [7:0]           idx0     [3];
  logic signed [FW-1:0] frac0    [3];

  assign crd[0] = in_data.coord_x;
  assign crd[1] = in_data.coord_y;
  assign crd[2] = in_data.coord_z;

  always_comb begin
    logic [F-1:0] low;
    logic         adj;
    for (int k = 0; k < 3; k++) begin
      low = crd[k][F-1:0];
      // Truncate toward zero: a negative value with a fraction rounds up.
      adj = crd[k][31] && (low != '0);
      idx_in[k]  = crd[k][F+7:F] + {7'b0, adj};
      frac_in[k] = $signed({2'b00, low}) - (adj ? ONE_F : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        idx0[k]  <= idx_in[k];
        frac0[k] <= frac_in[k];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Fade lanes, stages 1 to 4: f^3 * (f * (6f - 15) + 10)
  // ---------------------------------------------------------------------
  logic signed [MW-1:0]    m0     [3];
  logic signed [FW+MW-1:0] p1     [3];
  logic signed [2*FW-1:0]  p2     [3];
  logic signed [FW-1:0]    frac1  [3];
  logic signed [FW-1:0]    ff1    [3];
  logic signed [IW-1:0]    inner2 [3];
  logic signed [2*FW-1:0]  p3     [3];
  logic signed [FW-1:0]    frac2  [3];
  logic signed [FW-1:0]    cube2  [3];
  logic signed [IW+FW-1:0] p4     [3];
  logic signed [FW-1:0]    frac3  [3];
  logic [7:0]              yi1;
  logic [7:0]              zi1;
  logic [7:0]              zi2;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      m0[k]    = (MW'(frac0[k]) <<< 2) + (MW'(frac0[k]) <<< 1) - C15;
      ff1[k]   = FW'(p2[k] >>> F);
      cube2[k] = FW'(p3[k] >>> F);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        p1[k]     <= frac0[k] * m0[k];
        p2[k]     <= frac0[k] * frac0[k];
        frac1[k]  <= frac0[k];
        inner2[k] <= IW'(p1[k] >>> F) + C10;
        p3[k]     <= ff1[k] * frac1[k];
        frac2[k]  <= frac1[k];
        p4[k]     <= inner2[k] * cube2[k];
        frac3[k]  <= frac2[k];
      end
      yi1 <= idx0[1];
      zi1 <= idx0[2];
      zi2 <= zi1;
    end
  end

  // ---------------------------------------------------------------------
  // Table copies: copy 0 serves the first hash level and the sequencer,
  // copies 1-2 the second level, copies 3-6 the corner hashes.
  // ---------------------------------------------------------------------
  logic           ram_we;
  logic [TAW-1:0] ram_waddr;
  logic [7:0]     ram_wdata;
  logic           ram_re;
  logic           seq_re;
  logic [TAW-1:0] seq_ra;
  logic [TAW-1:0] seq_rb;
  logic [TAW-1:0] rda [NCOPY];
  logic [TAW-1:0] rdb [NCOPY];
  logic [7:0]     qa  [NCOPY];
  logic [7:0]     qb  [NCOPY];
  logic [TAW-1:0] ha;
  logic [TAW-1:0] hb;
  logic [TAW-1:0] haa;
  logic [TAW-1:0] hab;
  logic [TAW-1:0] hba;
  logic [TAW-1:0] hbb;

  assign ram_re = busy ? seq_re : adv;

  always_comb begin
    ha  = TAW'(qa[0]) + TAW'(yi1);
    hb  = TAW'(qb[0]) + TAW'(yi1);
    haa = TAW'(qa[1]) + TAW'(zi2);
    hab = TAW'(qb[1]) + TAW'(zi2);
    hba = TAW'(qa[2]) + TAW'(zi2);
    hbb = TAW'(qb[2]) + TAW'(zi2);
    rda[0] = busy ? seq_ra : TAW'(idx0[0]);
    rdb[0] = busy ? seq_rb : TAW'(idx0[0]) + TAW'(1);
    rda[1] = ha;
    rdb[1] = ha + TAW'(1);
    rda[2] = hb;
    rdb[2] = hb + TAW'(1);
    rda[3] = haa;
    rdb[3] = haa + TAW'(1);
    rda[4] = hab;
    rdb[4] = hab + TAW'(1);
    rda[5] = hba;
    rdb[5] = hba + TAW'(1);
    rda[6] = hbb;
    rdb[6] = hbb + TAW'(1);
  end

  for (genvar c = 0; c < NCOPY; c++) begin : g_copy
    perlin3d_ram #(
      .WIDTH (8),
      .DEPTH (TABLE_ENTRIES)
    ) u_ram (
      .clk     (clk),
      .we      (ram_we),
      .waddr   (ram_waddr),
      .wdata   (ram_wdata),
      .re      (ram_re),
      .raddr_a (rda[c]),
      .raddr_b (rdb[c]),
      .rdata_a (qa[c]),
      .rdata_b (qb[c])
    );
  end

  // ---------------------------------------------------------------------
  // Stage 4: finish fades, form the eight corner gradients
  // ---------------------------------------------------------------------
  logic signed [FW-1:0] xa, xb, ya, yb, za, zb;
  logic signed [GW-1:0] g_in [8];
  logic signed [GW-1:0] g4   [8];
  logic signed [UW-1:0] u4;
  logic signed [UW-1:0] vq [3];
  logic signed [UW-1:0] wq [5];

  always_comb begin
    xa = frac3[0];
    xb = frac3[0] - ONE_F;
    ya = frac3[1];
    yb = frac3[1] - ONE_F;
    za = frac3[2];
    zb = frac3[2] - ONE_F;
    g_in[0] = grad(qa[3][3:0], xa, ya, za);
    g_in[1] = grad(qa[5][3:0], xb, ya, za);
    g_in[2] = grad(qa[4][3:0], xa, yb, za);
    g_in[3] = grad(qa[6][3:0], xb, yb, za);
    g_in[4] = grad(qb[3][3:0], xa, ya, zb);
    g_in[5] = grad(qb[5][3:0], xb, ya, zb);
    g_in[6] = grad(qb[4][3:0], xa, yb, zb);
    g_in[7] = grad(qb[6][3:0], xb, yb, zb);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 8; k++) begin
        g4[k] <= g_in[k];
      end
      u4    <= UW'(p4[0] >>> F);
      vq[0] <= UW'(p4[1] >>> F);
      wq[0] <= UW'(p4[2] >>> F);
      // Carry the y and z weights to their lerp levels.
      for (int k = 1; k < 3; k++) begin
        vq[k] <= vq[k-1];
      end
      for (int k = 1; k < 5; k++) begin
        wq[k] <= wq[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Trilinear blend: x level (stages 5-6), y level (7-8), z level (9-10)
  // ---------------------------------------------------------------------
  logic signed [L1W-1:0] x6  [4];
  logic signed [L2W-1:0] y8  [2];
  logic signed [L3W-1:0] n10;

  for (genvar j = 0; j < 4; j++) begin : g_lx
    perlin3d_lerp #(
      .AW (GW), .TW (UW), .RW (L1W), .FB (F)
    ) u_lerp (
      .clk (clk), .en (adv),
      .a (g4[2*j]), .b (g4[2*j+1]), .t (u4),
      .y (x6[j])
    );
  end

  for (genvar j = 0; j < 2; j++) begin : g_ly
    perlin3d_lerp #(
      .AW (L1W), .TW (UW), .RW (L2W), .FB (F)
    ) u_lerp (
      .clk (clk), .en (adv),
      .a (x6[2*j]), .b (x6[2*j+1]), .t (vq[2]),
      .y (y8[j])
    );
  end

  perlin3d_lerp #(
    .AW (L2W), .TW (UW), .RW (L3W), .FB (F)
  ) u_lz (
    .clk (clk), .en (adv),
    .a (y8[0]), .b (y8[1]), .t (wq[4]),
    .y (n10)
  );

  // ---------------------------------------------------------------------
  // Output register: map (n + 1) / 2 to Q1.16 and saturate
  // ---------------------------------------------------------------------
  logic signed [VW-1:0] val;
  logic [QW-1:0]        qw;
  logic [16:0]          noise;

  always_comb begin
    val = (VW'(n10) + ONE_V) >>> 1;
    qw  = (QW'(val) << LSH) >> RSH;
    if (val <= 0) begin
      noise = '0;
    end else if (qw > QMAX) begin
      noise = NOISE_MAX;
    end else begin
      noise = qw[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[NSTG-1] || ack;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.noise_value   <= ack ? '0 : noise;
      out_data.is_reseed_ack <= ack;
    end
  end

  // ---------------------------------------------------------------------
  // Reseed sequencer: seed the generator, fill 0..255 twice, then swap
  // each entry with a random one; all copies take the same writes.
  // ---------------------------------------------------------------------
  logic [TAW-1:0]   sidx;
  logic [TAW-1:0]   sidx_next;
  logic [63:0]      rng_state;
  logic [63:0]      rng_state_next;
  logic [45:0]      lo_prod;
  logic [45:0]      lo_prod_next;
  logic [TAW-1:0]   swap_r;
  logic [TAW-1:0]   swap_r_next;
  logic [63:0]      xs;
  logic [45:0]      hi_prod;
  logic [2*TAW-1:0] r_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_state <= SQ_IDLE;
      sidx      <= '0;
      rng_state <= '0;
    end else begin
      seq_state <= seq_state_next;
      sidx      <= sidx_next;
      rng_state <= rng_state_next;
    end
  end

  always_ff @(posedge clk) begin
    lo_prod <= lo_prod_next;
    swap_r  <= swap_r_next;
  end

  assign xs      = xorshift(rng_state);
  assign r_prod  = xs[TAW-1:0] * RNG_MUL[TAW-1:0];
  assign hi_prod = rng_state[63:32] * SEED_MUL;

  always_comb begin
    seq_state_next = seq_state;
    sidx_next      = sidx;
    rng_state_next = rng_state;
    lo_prod_next   = lo_prod;
    swap_r_next    = swap_r;
    ram_we         = 1'b0;
    ram_waddr      = sidx;
    ram_wdata      = sidx[7:0];
    seq_re         = 1'b0;
    seq_ra         = sidx;
    seq_rb         = swap_r;
    ack            = 1'b0;
    unique case (seq_state)
      SQ_IDLE: begin
        if (reseed_acc) begin
          rng_state_next = seed + 64'd1;
          seq_state_next = SQ_MUL_LO;
        end
      end
      SQ_MUL_LO: begin
        lo_prod_next   = rng_state[31:0] * SEED_MUL;
        seq_state_next = SQ_MUL_HI;
      end
      SQ_MUL_HI: begin
        rng_state_next = {18'b0, lo_prod} + {hi_prod[31:0], 32'b0};
        sidx_next      = '0;
        seq_state_next = SQ_FILL;
      end
      SQ_FILL: begin
        ram_we    = 1'b1;
        sidx_next = sidx + TAW'(1);
        if (sidx == LAST) begin
          seq_state_next = SQ_SWAP_RD;
        end
      end
      SQ_SWAP_RD: begin
        // Advance the generator and read both swap partners.
        rng_state_next = xs;
        swap_r_next    = r_prod[TAW-1:0];
        seq_re         = 1'b1;
        seq_rb         = r_prod[TAW-1:0];
        seq_state_next = SQ_SWAP_WI;
      end
      SQ_SWAP_WI: begin
        ram_we         = 1'b1;
        ram_wdata      = qb[0];
        seq_state_next = SQ_SWAP_WR;
      end
      SQ_SWAP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = swap_r;
        ram_wdata = qa[0];
        sidx_next = sidx + TAW'(1);
        seq_state_next = (sidx == LAST) ? SQ_DONE : SQ_SWAP_RD;
      end
      SQ_DONE: begin
        // Drop the ack into the output register once it is free.
        if (adv) begin
          ack            = 1'b1;
          seq_state_next = SQ_IDLE;
        end
      end
      default: begin
        seq_state_next = SQ_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_busy_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    busy |-> (vld == '0))
    else $error("evaluate request in flight during reseed");

  a_ack_from_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.is_reseed_ack && !$past(out_valid && out_stall))
      |-> $past(seq_state == SQ_DONE))
    else $error("reseed ack without finished sequencer");

endmodule
`default_nettype wire

### verif/perlin_noise_3d_test.sv
// Testbench for perlin_noise_3d: streams reseed and evaluate requests, predicts noise.
`default_nettype none
module perlin_noise_3d_test
  import perlin3d_pkg::*;
();

  localparam int FB = 16;
  localparam longint ONE_Q = 64'sd1 << FB;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [63:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  noise_req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  noise_res_t out_data;

  perlin_noise_3d uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: our own copy of the shuffled table and the seed register.
  logic [7:0] perm [TABLE_ENTRIES];
  logic [63:0] seed_reg = '0;

  noise_req_t pending_reqs [$];
  noise_res_t expected_noise [$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit quiet_tail = 1'b0;
  bit stim_done = 1'b0;
  int hold_off = 0;
  bit hold_req = 1'b0;
  bit hold_used = 1'b0;

  function automatic longint fshift(longint v, int s);
    return v >>> s;  // arithmetic shift floors toward minus infinity
  endfunction

  function automatic longint qmul(longint a, longint b);
    longint ah, al;
    ah = fshift(a, FB);
    al = a - ah * ONE_Q;
    return ah * b + fshift(al * b, FB);
  endfunction

  function automatic longint smooth(longint f);
    longint inner, cube;
    inner = qmul(f, 6 * f - 15 * ONE_Q) + 10 * ONE_Q;
    cube = qmul(qmul(f, f), f);
    return qmul(inner, cube);
  endfunction

  function automatic longint blend(longint a, longint b, longint t);
    return a + qmul(b - a, t);
  endfunction

  function automatic longint gdot(int hash, longint x, longint y, longint z);
    int h;
    longint u, v;
    h = hash & 15;
    u = (h < 8) ? x : y;
    v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic int tbl(int i);
    return int'(perm[i & (TABLE_ENTRIES - 1)]);
  endfunction

  // Truncate toward zero: lattice index and signed fraction.
  function automatic void split_coord(input logic signed [31:0] c, output int idx,
                                      output longint frac);
    longint cv, ip;
    cv = longint'(c);
    ip = (cv >= 0) ? (cv >>> FB) : -((-cv) >>> FB);
    frac = cv - ip * ONE_Q;
    idx = int'(ip & 255);
  endfunction

  task automatic shuffle_table();
    logic [63:0] st, r;
    logic [7:0] t;
    int j;
    st = (seed_reg + 64'd1) * 64'd12907;
    for (int i = 0; i < 256; i++) begin
      perm[i] = i[7:0];
      perm[i + 256] = i[7:0];
    end
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      st ^= st >> XS_A;
      st ^= st << XS_B;
      st ^= st >> XS_C;
      r = st * RNG_MUL;
      j = int'(r[8:0]);
      t = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
  endtask

  function automatic noise_res_t noise_at(noise_req_t rq);
    noise_res_t res;
    int xi, yi, zi, a, b, aa, ab, ba, bb;
    longint xf, yf, zf, u, v, w, x1, x2, y1, y2, n, val;
    split_coord(rq.coord_x, xi, xf);
    split_coord(rq.coord_y, yi, yf);
    split_coord(rq.coord_z, zi, zf);
    u = smooth(xf);
    v = smooth(yf);
    w = smooth(zf);
    a = tbl(xi) + yi;
    aa = tbl(a) + zi;
    ab = tbl(a + 1) + zi;
    b = tbl(xi + 1) + yi;
    ba = tbl(b) + zi;
    bb = tbl(b + 1) + zi;
    x1 = blend(gdot(tbl(aa), xf, yf, zf), gdot(tbl(ba), xf - ONE_Q, yf, zf), u);
    x2 = blend(gdot(tbl(ab), xf, yf - ONE_Q, zf),
               gdot(tbl(bb), xf - ONE_Q, yf - ONE_Q, zf), u);
    y1 = blend(x1, x2, v);
    x1 = blend(gdot(tbl(aa + 1), xf, yf, zf - ONE_Q),
               gdot(tbl(ba + 1), xf - ONE_Q, yf, zf - ONE_Q), u);
    x2 = blend(gdot(tbl(ab + 1), xf, yf - ONE_Q, zf - ONE_Q),
               gdot(tbl(bb + 1), xf - ONE_Q, yf - ONE_Q, zf - ONE_Q), u);
    y2 = blend(x1, x2, v);
    n = blend(y1, y2, w);
    val = fshift(n + ONE_Q, 1);
    if (val <= 0) val = 0;
    if (val > 65536) val = 65536;
    res.noise_value = val[16:0];
    res.is_reseed_ack = 1'b0;
    return res;
  endfunction

  // Compute the expected result at the moment a request is taken.
  task automatic predict(noise_req_t rq);
    noise_res_t res;
    if (rq.req_type == REQ_RESEED) begin
      shuffle_table();
      res.noise_value = '0;
      res.is_reseed_ack = 1'b1;
    end else begin
      res = noise_at(rq);
    end
    expected_noise.push_back(res);
  endtask

  // Driver: present the next pending request, idle in random bursts.
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) predict(in_data);
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          in_data <= pending_reqs.pop_front();
          in_valid <= 1'b1;
          if (!quiet_tail && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 6);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off: once asked for, wait until requests are in flight, then
  // count down hold_off while the monitor holds out_stall.
  always @(posedge clk) begin
    if (!rst) begin
      if (hold_req && !hold_used && expected_noise.size() >= 4) begin
        hold_used <= 1'b1;
        hold_off <= 300;
      end else if (hold_off > 0) begin
        hold_off <= hold_off - 1;
      end
    end
  end

  // Monitor: check each result and drive random stall bursts on the output.
  int stall_run = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_noise.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_data);
        end else begin
          noise_res_t e;
          e = expected_noise.pop_front();
          if (e.noise_value !== out_data.noise_value ||
              e.is_reseed_ack !== out_data.is_reseed_ack) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected noise %0d ack %0b, got noise %0d ack %0b",
                       e.noise_value, e.is_reseed_ack, out_data.noise_value,
                       out_data.is_reseed_ack);
          end
        end
      end
      if (hold_off > 0) begin
        out_stall <= 1'b1;
      end else if (stall_run > 0) begin
        stall_run <= stall_run - 1;
        out_stall <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        stall_run <= $urandom_range(0, 5);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: count cycles in which no request and no result moves.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
      2: return {16'($urandom_range(0, 3)) - 16'd2, 16'($urandom())};
      default: return {{15{1'b0}}, 17'($urandom())} - 32'h10000;
    endcase
  endfunction

  function automatic noise_req_t eval_req(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    noise_req_t r;
    r.req_type = REQ_EVAL;
    r.coord_x = x;
    r.coord_y = y;
    r.coord_z = z;
    return r;
  endfunction

  function automatic noise_req_t reseed_req();
    noise_req_t r;
    r = eval_req($urandom(), $urandom(), $urandom());
    r.req_type = REQ_RESEED;
    return r;
  endfunction

  // Wait for the block to drain so the seed can be rewritten while idle.
  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_noise.size() > 0)
      @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_seed(logic [63:0] s);
    cfg_we <= 1'b1;
    cfg_wdata <= s;
    seed_reg = s;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [63:0] seeds [6];
    seeds = '{64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE, 64'd1,
              {$urandom(), $urandom()}, {$urandom(), $urandom()}};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int p = 0; p < 6; p++) begin
      write_seed(seeds[p]);
      pending_reqs.push_back(reseed_req());
      if (p == 0) begin
        // Hit field extremes, zero, exact lattice points and negative fractions.
        pending_reqs.push_back(eval_req(32'h0, 32'h0, 32'h0));
        pending_reqs.push_back(eval_req(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        pending_reqs.push_back(eval_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        pending_reqs.push_back(eval_req(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_0000));
        pending_reqs.push_back(eval_req(32'h0000_8000, 32'hFFFF_8000, 32'h0001_8000));
        pending_reqs.push_back(eval_req(32'h00FF_FFFF, 32'hFF00_0001, 32'h0100_0000));
        pending_reqs.push_back(eval_req(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF));
        // Block the output for a long time while requests keep coming.
        for (int i = 0; i < 60; i++)
          pending_reqs.push_back(eval_req(rand_coord(), rand_coord(), rand_coord()));
        hold_req = 1'b1;
      end
      for (int i = 0; i < 212; i++) begin
        if (i == 90 && $urandom_range(0, 1) == 1) pending_reqs.push_back(reseed_req());
        pending_reqs.push_back(eval_req(rand_coord(), rand_coord(), rand_coord()));
      end
      if (p == 5) quiet_tail = 1'b1;
      drain();
    end
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire

### filelist.f
sv/perlin3d_pkg.sv
sv/perlin3d_ram.sv
sv/perlin3d_lerp.sv
sv/perlin_noise_3d.sv
verif/perlin_noise_3d_test.sv
